@@ src/histeq_pkg.sv @@
package histeq_pkg;

   // Sizes of the histogram, the gray scale and the counts
   localparam int unsigned BIN_W      = 8;
   localparam int unsigned BIN_COUNT  = 256;
   localparam int unsigned COUNT_W    = 23;
   localparam int unsigned SCALE_W    = 32;
   localparam int unsigned MAX_PIXELS = 4194304;
   localparam logic [BIN_W-1:0] LEVEL_MAX = 8'd255;

   // Divide by three as multiply by 683/2048, exact for sums up to 765
   localparam int unsigned SUM_W       = 10;
   localparam int unsigned PROD_W      = 20;
   localparam int unsigned RECIP_SHIFT = 11;
   localparam logic [SUM_W-1:0] RECIP_3 = 10'd683;

   // Result queue
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = 2;
   localparam int unsigned FIFO_CW    = 3;

   typedef enum logic [1:0] {
      CMD_ACCUM = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_MAP   = 2'd2
   } cmd_type;

   typedef enum logic {
      KIND_MAP   = 1'b0,
      KIND_BUILD = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      BLD_IDLE,
      BLD_READ,
      BLD_ADD,
      BLD_STEP
   } bld_state_type;

   // One result, packed as it leaves on the result channel
   typedef struct packed {
      logic               overflow;
      logic [COUNT_W-1:0] pixels;
      logic [BIN_W-1:0]   gray;
      kind_type           kind;
   } rsp_item_type;

   // Builder towards the memories and the top level
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [BIN_W-1:0] rd_addr;
      logic             map_we;
      logic [BIN_W-1:0] map_addr;
      logic [BIN_W-1:0] map_data;
   } bld_ctl_type;

   // Gray level = floor((r + g + b) / 3)
   function automatic logic [BIN_W-1:0] gray_of(input logic [BIN_W-1:0] r,
                                                input logic [BIN_W-1:0] g,
                                                input logic [BIN_W-1:0] b);
      logic [SUM_W-1:0]  sum;
      logic [PROD_W-1:0] prod;
      sum  = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
      prod = PROD_W'(sum) * PROD_W'(RECIP_3);
      return prod[RECIP_SHIFT +: BIN_W];
   endfunction

endpackage

@@ src/histogram_equalizer.sv @@
// Channel    | Direction | Handshake            | Payload
// req_       | in        | req_tvalid/tready    | tuser: command; tdata: red, green, blue
// rsp_       | out       | rsp_tvalid/tready    | tuser: kind; tdata: gray_out, pixels_counted,
//            |           |                      | overflow
//
// Accumulate and map transactions go through a two-stage pipe at one per cycle while
// req_tready is high: an accumulate does a read-modify-write of the bin memory, a map reads
// the map memory and queues its result from the second stage. A build walks the 256 bins in
// turn (read, add, level step, write entry), with no input accepted meanwhile.
// Reset is synchronous; the bin and map memories read as zero after reset.
// A stalled result channel backs up into a four-entry queue, then stops acceptance.
module histogram_equalizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] gray_out, [30:8] pixels_counted, [31] overflow
   output logic [0:0]  rsp_tuser    // [0] kind
);

   logic                                 accept;
   histeq_pkg::cmd_type                  req_cmd;
   logic [histeq_pkg::BIN_W-1:0]         req_gray;

   logic                                 s1_v_ff, s2_v_ff;
   histeq_pkg::cmd_type                  s1_cmd_ff, s2_cmd_ff;
   logic [histeq_pkg::BIN_W-1:0]         s1_gray_ff, s2_gray_ff;
   logic                                 s1_inc_ff, s2_inc_ff;

   logic [histeq_pkg::COUNT_W-1:0]       total_ff, total_in;
   logic                                 sat_ff, sat_in;
   logic                                 inc;
   logic                                 build_pend_ff;

   logic                                 lw_v_ff;
   logic [histeq_pkg::BIN_W-1:0]         lw_addr_ff;
   logic [histeq_pkg::COUNT_W-1:0]       lw_data_ff;

   logic [histeq_pkg::BIN_W-1:0]         hist_rd_addr;
   logic [histeq_pkg::COUNT_W-1:0]       hist_rd_data;
   logic [histeq_pkg::COUNT_W-1:0]       bin_cur;
   logic                                 hist_we;
   logic [histeq_pkg::COUNT_W-1:0]       hist_wr_data;
   logic [histeq_pkg::BIN_W-1:0]         map_rd_data;

   histeq_pkg::bld_ctl_type              bld;
   logic                                 bld_start;

   logic                                 fifo_push;
   histeq_pkg::rsp_item_type             fifo_in;
   histeq_pkg::rsp_item_type             fifo_head;
   logic [histeq_pkg::FIFO_CW-1:0]       fifo_count;
   logic [histeq_pkg::FIFO_CW-1:0]       occupancy;

   // Input side: room for every transaction in flight, none while a build is due
   assign occupancy  = fifo_count + histeq_pkg::FIFO_CW'(s1_v_ff)
                                  + histeq_pkg::FIFO_CW'(s2_v_ff);
   assign req_tready = !build_pend_ff &&
                       (occupancy < histeq_pkg::FIFO_CW'(histeq_pkg::FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign req_cmd    = histeq_pkg::cmd_type'(req_tuser);
   assign req_gray   = histeq_pkg::gray_of(req_tdata[7:0], req_tdata[15:8],
                                           req_tdata[23:16]);

   // Pixel count and saturation flag, settled at acceptance and cleared when a build ends
   always_comb begin
      total_in = total_ff;
      sat_in   = sat_ff;
      inc      = 1'b0;
      if (bld.done) begin
         total_in = '0;
         sat_in   = 1'b0;
      end else if (accept && (req_cmd == histeq_pkg::CMD_ACCUM)) begin
         if (total_ff >= histeq_pkg::COUNT_W'(histeq_pkg::MAX_PIXELS)) begin
            sat_in = 1'b1;
         end else begin
            total_in = total_ff + 1'b1;
            inc      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         sat_ff        <= 1'b0;
         build_pend_ff <= 1'b0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         lw_v_ff       <= 1'b0;
      end else begin
         total_ff <= total_in;
         sat_ff   <= sat_in;
         if (bld.done) begin
            build_pend_ff <= 1'b0;
         end else if (accept && (req_cmd == histeq_pkg::CMD_BUILD)) begin
            build_pend_ff <= 1'b1;
         end
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
         lw_v_ff <= hist_we;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      s1_cmd_ff  <= req_cmd;
      s1_gray_ff <= req_gray;
      s1_inc_ff  <= inc;
      s2_cmd_ff  <= s1_cmd_ff;
      s2_gray_ff <= s1_gray_ff;
      s2_inc_ff  <= s1_inc_ff;
      lw_addr_ff <= s2_gray_ff;
      lw_data_ff <= hist_wr_data;
   end

   // Bin update; the previous write is forwarded when it hit the same bin
   assign bin_cur      = (lw_v_ff && (lw_addr_ff == s2_gray_ff)) ? lw_data_ff : hist_rd_data;
   assign hist_wr_data = bin_cur + 1'b1;
   assign hist_we      = s2_v_ff && (s2_cmd_ff == histeq_pkg::CMD_ACCUM) && s2_inc_ff;
   assign hist_rd_addr = bld.busy ? bld.rd_addr : s1_gray_ff;
   assign bld_start    = s2_v_ff && (s2_cmd_ff == histeq_pkg::CMD_BUILD);

   histeq_hist_mem u_hist (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (hist_rd_addr),
      .rd_data   (hist_rd_data),
      .wr_en     (hist_we),
      .wr_addr   (s2_gray_ff),
      .wr_data   (hist_wr_data),
      .clear_all (bld.done)
   );

   histeq_map_mem u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (s1_gray_ff),
      .rd_data (map_rd_data),
      .wr_en   (bld.map_we),
      .wr_addr (bld.map_addr),
      .wr_data (bld.map_data)
   );

   histeq_builder u_bld (
      .clock     (clock),
      .reset     (reset),
      .start     (bld_start),
      .total     (total_ff),
      .hist_data (hist_rd_data),
      .ctl       (bld)
   );

   // Results: a mapped pixel from the pipe or the end of a build
   always_comb begin
      fifo_push = 1'b0;
      fifo_in   = '0;
      if (bld.done) begin
         fifo_push        = 1'b1;
         fifo_in.kind     = histeq_pkg::KIND_BUILD;
         fifo_in.pixels   = total_ff;
         fifo_in.overflow = sat_ff;
      end else if (s2_v_ff && (s2_cmd_ff == histeq_pkg::CMD_MAP)) begin
         fifo_push    = 1'b1;
         fifo_in.kind = histeq_pkg::KIND_MAP;
         fifo_in.gray = map_rd_data;
      end
   end

   histeq_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (fifo_push),
      .push_item  (fifo_in),
      .pop        (rsp_tvalid && rsp_tready),
      .head_item  (fifo_head),
      .head_valid (rsp_tvalid),
      .count      (fifo_count)
   );

   assign rsp_tdata = {fifo_head.overflow, fifo_head.pixels, fifo_head.gray};
   assign rsp_tuser = fifo_head.kind;

endmodule

@@ src/histeq_hist_mem.sv @@
module histeq_hist_mem (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [histeq_pkg::BIN_W-1:0]        rd_addr,
   output logic [histeq_pkg::COUNT_W-1:0]      rd_data,
   input  logic                                wr_en,
   input  logic [histeq_pkg::BIN_W-1:0]        wr_addr,
   input  logic [histeq_pkg::COUNT_W-1:0]      wr_data,
   input  logic                                clear_all
);

   logic [histeq_pkg::COUNT_W-1:0]   mem_ff [histeq_pkg::BIN_COUNT];
   logic [histeq_pkg::COUNT_W-1:0]   rd_data_ff;
   logic                             rd_valid_ff;
   logic [histeq_pkg::BIN_COUNT-1:0] valid_ff;

   // Bin storage, read before write on a shared address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // Per-bin valid bits; a bin never written since the last clear reads as zero
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ src/histeq_map_mem.sv @@
module histeq_map_mem (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [histeq_pkg::BIN_W-1:0]   rd_addr,
   output logic [histeq_pkg::BIN_W-1:0]   rd_data,
   input  logic                           wr_en,
   input  logic [histeq_pkg::BIN_W-1:0]   wr_addr,
   input  logic [histeq_pkg::BIN_W-1:0]   wr_data
);

   logic [histeq_pkg::BIN_W-1:0] mem_ff [histeq_pkg::BIN_COUNT];
   logic [histeq_pkg::BIN_W-1:0] rd_data_ff;
   logic                         built_ff;

   // Mapping table storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // Every build rewrites all entries, so one flag covers the reset table
   always_ff @(posedge clock) begin
      if (reset) begin
         built_ff <= 1'b0;
      end else if (wr_en) begin
         built_ff <= 1'b1;
      end
   end

   assign rd_data = built_ff ? rd_data_ff : '0;

endmodule

@@ src/histeq_builder.sv @@
module histeq_builder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [histeq_pkg::COUNT_W-1:0]    total,
   input  logic [histeq_pkg::COUNT_W-1:0]    hist_data,
   output histeq_pkg::bld_ctl_type           ctl
);

   histeq_pkg::bld_state_type        state_ff, state_in;
   logic [histeq_pkg::BIN_W-1:0]     idx_ff, idx_in;
   logic [histeq_pkg::SCALE_W-1:0]   scaled_ff, scaled_in;
   logic [histeq_pkg::SCALE_W-1:0]   thresh_ff, thresh_in;
   logic [histeq_pkg::BIN_W-1:0]     level_ff, level_in;
   logic [histeq_pkg::SCALE_W-1:0]   hist_wide;
   logic [histeq_pkg::SCALE_W-1:0]   total_wide;
   logic                             step_up;

   assign hist_wide  = histeq_pkg::SCALE_W'(hist_data);
   assign total_wide = histeq_pkg::SCALE_W'(total);

   // Level moves up while (level+1)*total still fits under 255*cumulative
   assign step_up = (total != '0) && (level_ff != histeq_pkg::LEVEL_MAX) &&
                    (thresh_ff <= scaled_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= histeq_pkg::BLD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      scaled_ff <= scaled_in;
      thresh_ff <= thresh_in;
      level_ff  <= level_in;
   end

   // Sweep: read a bin, add it to the scaled sum, step the level, write the entry
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      scaled_in    = scaled_ff;
      thresh_in    = thresh_ff;
      level_in     = level_ff;
      ctl.busy     = (state_ff != histeq_pkg::BLD_IDLE);
      ctl.done     = 1'b0;
      ctl.rd_addr  = idx_ff;
      ctl.map_we   = 1'b0;
      ctl.map_addr = idx_ff;
      ctl.map_data = (total == '0) ? '0 : level_ff;
      unique case (state_ff)
         histeq_pkg::BLD_IDLE: begin
            if (start) begin
               idx_in    = '0;
               scaled_in = '0;
               thresh_in = total_wide;
               level_in  = '0;
               state_in  = histeq_pkg::BLD_READ;
            end
         end
         histeq_pkg::BLD_READ: begin
            state_in = histeq_pkg::BLD_ADD;
         end
         histeq_pkg::BLD_ADD: begin
            scaled_in = scaled_ff + (hist_wide << 8) - hist_wide;
            state_in  = histeq_pkg::BLD_STEP;
         end
         histeq_pkg::BLD_STEP: begin
            if (step_up) begin
               level_in  = level_ff + 1'b1;
               thresh_in = thresh_ff + total_wide;
            end else begin
               ctl.map_we = 1'b1;
               if (idx_ff == histeq_pkg::LEVEL_MAX) begin
                  ctl.done = 1'b1;
                  state_in = histeq_pkg::BLD_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = histeq_pkg::BLD_READ;
               end
            end
         end
         default: begin
            state_in = histeq_pkg::BLD_IDLE;
         end
      endcase
   end

endmodule

@@ src/histeq_rsp_fifo.sv @@
module histeq_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  histeq_pkg::rsp_item_type          push_item,
   input  logic                              pop,
   output histeq_pkg::rsp_item_type          head_item,
   output logic                              head_valid,
   output logic [histeq_pkg::FIFO_CW-1:0]    count
);

   histeq_pkg::rsp_item_type             mem_ff [histeq_pkg::FIFO_DEPTH];
   logic [histeq_pkg::FIFO_AW-1:0]       wr_ptr_ff;
   logic [histeq_pkg::FIFO_AW-1:0]       rd_ptr_ff;
   logic [histeq_pkg::FIFO_CW-1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + histeq_pkg::FIFO_CW'(push) - histeq_pkg::FIFO_CW'(pop);
      end
   end

   assign head_item  = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign count      = count_ff;

endmodule

@@ src/histeq_checker.sv @@
module histeq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // A held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // An accepted build transaction closes the input straight after it
   a_build_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == histeq_pkg::CMD_BUILD) |=> !req_tready)
      else $error("input accepted right after a build transaction");

   // Mapped pixels carry no count and no overflow
   a_map_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == histeq_pkg::KIND_MAP) |-> rsp_tdata[31:8] == '0)
      else $error("map result with count fields set");

   // Build results carry no gray level and a count within the limit
   a_build_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == histeq_pkg::KIND_BUILD) |->
         (rsp_tdata[7:0] == '0) &&
         (rsp_tdata[30:8] <= histeq_pkg::COUNT_W'(histeq_pkg::MAX_PIXELS)))
      else $error("build result fields out of range");

endmodule

bind histogram_equalizer histeq_checker u_histeq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Command code the block leaves unused and must ignore
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // Slowest legal run is every item a build plus idling; allow a wide margin
   localparam int unsigned CYCLE_LIMIT  = 8_000_000;
   localparam int unsigned DRAIN_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [7:0] red, [15:8] green, [23:16] blue
   logic [1:0]  req_tuser = '0;   // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [7:0] gray_out, [30:8] pixels_counted, [31] overflow
   logic [0:0]  rsp_tuser;        // [0] kind

   // Predicted histogram, mapping table and pixel count
   logic [histeq_pkg::COUNT_W-1:0] bin_tally [histeq_pkg::BIN_COUNT];
   logic [histeq_pkg::BIN_W-1:0]   level_map [histeq_pkg::BIN_COUNT];
   int unsigned                    tally_total;
   bit                             tally_clipped;

   histeq_pkg::rsp_item_type pending_rsp [$];

   int unsigned mismatches = 0;
   int unsigned items_done = 0;
   int unsigned cycles     = 0;
   int unsigned hold_off   = 0;
   int unsigned stall_left = 0;
   bit          idling     = 1'b1;

   histogram_equalizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Predictor: state after reset
   function automatic void clear_tally();
      for (int unsigned i = 0; i < histeq_pkg::BIN_COUNT; i++) bin_tally[i] = '0;
      tally_total   = 0;
      tally_clipped = 1'b0;
   endfunction

   // Predictor: one accepted transaction, queueing any result it causes
   function automatic void equalize_step(input logic [1:0] cmd,
                                         input logic [7:0] r, g, b);
      int unsigned               level;
      longint unsigned           running;
      longint unsigned           scaled;
      histeq_pkg::rsp_item_type  res;
      level = (int'(r) + int'(g) + int'(b)) / 3;
      res   = '0;
      case (cmd)
         histeq_pkg::CMD_ACCUM: begin
            if (tally_total >= histeq_pkg::MAX_PIXELS) begin
               tally_clipped = 1'b1;
            end else begin
               bin_tally[level] += 1'b1;
               tally_total++;
            end
         end
         histeq_pkg::CMD_BUILD: begin
            running = 0;
            for (int unsigned i = 0; i < histeq_pkg::BIN_COUNT; i++) begin
               running += bin_tally[i];
               if (tally_total == 0) begin
                  level_map[i] = '0;
               end else begin
                  scaled = (longint'(histeq_pkg::LEVEL_MAX) * running) / tally_total;
                  if (scaled > histeq_pkg::LEVEL_MAX) scaled = histeq_pkg::LEVEL_MAX;
                  level_map[i] = scaled[histeq_pkg::BIN_W-1:0];
               end
            end
            res.kind     = histeq_pkg::KIND_BUILD;
            res.pixels   = tally_total[histeq_pkg::COUNT_W-1:0];
            res.overflow = tally_clipped;
            pending_rsp.push_back(res);
            clear_tally();
         end
         histeq_pkg::CMD_MAP: begin
            res.kind = histeq_pkg::KIND_MAP;
            res.gray = level_map[level];
            pending_rsp.push_back(res);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name,
                                       input int unsigned want, got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // Result checker: each accepted transaction against the oldest prediction
   always @(posedge clock) begin
      histeq_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = pending_rsp.pop_front();
            check_field("kind", want.kind, rsp_tuser[0]);
            check_field("gray_out", want.gray, rsp_tdata[7:0]);
            check_field("pixels_counted", want.pixels, rsp_tdata[30:8]);
            check_field("overflow", want.overflow, rsp_tdata[31]);
         end
      end
   end

   // Result receiver: long hold-off when asked, else random stall bursts while idling
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one pixel transaction; entered and left at a falling edge
   task automatic send_pixel(input logic [1:0] cmd, input logic [7:0] r, g, b);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {b, g, r};
      do @(posedge clock); while (!req_tready);
      equalize_step(cmd, r, g, b);
      if (cmd != CMD_UNUSED) items_done++;
      @(negedge clock);
   endtask

   // Colour component, either anywhere or clustered around a base level
   function automatic logic [7:0] pick_component(input bit narrow, input int base);
      int v;
      if (!narrow) return 8'($urandom_range(0, 255));
      v = base + int'($urandom_range(0, 16)) - 8;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   task automatic send_random(input logic [1:0] cmd, input bit narrow, input int base);
      send_pixel(cmd, pick_component(narrow, base), pick_component(narrow, base),
                 pick_component(narrow, base));
   endtask

   // One frame: accumulate, build, then map; some noise and some frames without a build
   task automatic run_frame(input int n_acc, input int n_map, input bit narrow);
      int base;
      base = $urandom_range(0, 255);
      repeat (n_acc) begin
         if ($urandom_range(0, 19) == 0)
            send_random(2'($urandom_range(0, 3)), 1'b0, base);
         else
            send_random(histeq_pkg::CMD_ACCUM, narrow, base);
      end
      if ($urandom_range(0, 9) != 0) send_random(histeq_pkg::CMD_BUILD, 1'b0, base);
      repeat (n_map) send_random(histeq_pkg::CMD_MAP, narrow && $urandom_range(0, 1), base);
   endtask

   // Extremes, every command, empty builds, unmapped and ignored transactions
   task automatic test_directed();
      send_pixel(histeq_pkg::CMD_MAP, 8'd0, 8'd0, 8'd0);         // map before any build
      send_pixel(histeq_pkg::CMD_MAP, 8'd255, 8'd255, 8'd255);
      send_pixel(histeq_pkg::CMD_BUILD, 8'd0, 8'd0, 8'd0);       // build, empty histogram
      send_pixel(histeq_pkg::CMD_ACCUM, 8'd0, 8'd0, 8'd0);
      send_pixel(histeq_pkg::CMD_ACCUM, 8'd255, 8'd255, 8'd255);
      send_pixel(histeq_pkg::CMD_ACCUM, 8'd255, 8'd255, 8'd254);
      send_pixel(histeq_pkg::CMD_ACCUM, 8'd1, 8'd1, 8'd0);
      send_pixel(histeq_pkg::CMD_ACCUM, 8'd2, 8'd0, 8'd0);
      send_pixel(histeq_pkg::CMD_ACCUM, 8'd128, 8'd64, 8'd32);
      send_pixel(CMD_UNUSED, 8'd255, 8'd255, 8'd255);
      send_pixel(histeq_pkg::CMD_ACCUM, 8'd0, 8'd0, 8'd255);
      send_pixel(histeq_pkg::CMD_BUILD, 8'd255, 8'd255, 8'd255);
      send_pixel(histeq_pkg::CMD_MAP, 8'd0, 8'd0, 8'd0);
      send_pixel(histeq_pkg::CMD_MAP, 8'd255, 8'd255, 8'd255);
      send_pixel(histeq_pkg::CMD_MAP, 8'd255, 8'd255, 8'd254);
      send_pixel(histeq_pkg::CMD_MAP, 8'd100, 8'd100, 8'd100);
      send_pixel(CMD_UNUSED, 8'd0, 8'd0, 8'd0);
      send_pixel(histeq_pkg::CMD_MAP, 8'd3, 8'd0, 8'd0);         // map kept until next build
      send_pixel(histeq_pkg::CMD_BUILD, 8'd0, 8'd0, 8'd0);       // empty again: map to zero
      send_pixel(histeq_pkg::CMD_MAP, 8'd255, 8'd255, 8'd255);
   endtask

   // Random frames, with idling switched off for some of them
   task automatic test_random_frames(input int unsigned target);
      while (items_done < target) begin
         idling = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 7) == 0)
            run_frame($urandom_range(60, 120), $urandom_range(1, 10), $urandom_range(0, 1));
         else
            run_frame($urandom_range(0, 40), $urandom_range(1, 40), $urandom_range(0, 1));
      end
      idling = 1'b1;
   endtask

   // Receiver holds off while maps keep coming, so the block fills and stalls
   task automatic test_output_stall();
      idling = 1'b0;
      repeat (30) send_random(histeq_pkg::CMD_ACCUM, 1'b0, 0);
      hold_off = 80;
      repeat (40) send_random(histeq_pkg::CMD_MAP, 1'b0, 0);
      idling = 1'b1;
   endtask

   // Closing stretch with no idling on either side
   task automatic test_steady_stream(input int unsigned target);
      idling = 1'b0;
      while (items_done < target)
         run_frame($urandom_range(5, 30), $urandom_range(5, 30), $urandom_range(0, 1));
   endtask

   initial begin
      clear_tally();
      for (int unsigned i = 0; i < histeq_pkg::BIN_COUNT; i++) level_map[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_frames(1350);
      test_output_stall();
      test_steady_stream(1530);
      req_tvalid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ histogram_equalizer.f @@
src/histeq_pkg.sv
src/histeq_hist_mem.sv
src/histeq_map_mem.sv
src/histeq_builder.sv
src/histeq_rsp_fifo.sv
src/histogram_equalizer.sv
src/histeq_checker.sv
tb/tb.sv
